>>> src/gqi_pkg.sv
// ----------------------------------------------------------------------------
// gqi_pkg
// Shared types, constants and helpers for the gyro quaternion integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqi_pkg;

  // Default fraction width of the quaternion parts (Q2.FRAC_BITS).
  localparam int FRAC_BITS_DEFAULT = 30;

  // Reset value of the sample interval register (about ten milliseconds).
  localparam logic [23:0] STEP_TIME_RESET = 24'd167772;

  // Number of steps of the bitwise square root over a 64-bit sum.
  localparam int ROOT_STEPS = 32;

  // Quaternion part indexes.
  localparam logic [1:0] Q_W = 2'd0;
  localparam logic [1:0] Q_X = 2'd1;
  localparam logic [1:0] Q_Y = 2'd2;
  localparam logic [1:0] Q_Z = 2'd3;

  // Rate axis indexes.
  localparam logic [1:0] R_X = 2'd0;
  localparam logic [1:0] R_Y = 2'd1;
  localparam logic [1:0] R_Z = 2'd2;

  // One input beat: a gyro sample.
  typedef struct packed {
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
  } gqi_in_t;

  // One output beat: the normalised orientation.
  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } gqi_out_t;

  typedef logic [3:0][31:0] gqi_quat_t;
  typedef logic [2:0][23:0] gqi_rate_t;
  typedef logic [3:0][39:0] gqi_mags_t;
  typedef logic [3:0][63:0] gqi_squares_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_PEAK,
    ST_SHIFT,
    ST_SHRINK,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } gqi_state_t;

  // Step strobes from the sequencer to the lanes and the merging stage.
  typedef struct packed {
    logic       mac;
    logic [1:0] term;
    logic       scale_a;
    logic       scale_b;
    logic       peak;
    logic       shift;
    logic       shrink;
    logic       square;
    logic       sum;
    logic       root;
    logic       div_load;
    logic       div_step;
  } gqi_ctrl_t;

  // One product term of a derivative sum.
  typedef struct packed {
    logic [1:0] q_idx;
    logic [1:0] r_idx;
    logic       neg;
  } gqi_term_t;

  // Operand selection of the quaternion-rate product for each lane and term.
  function automatic gqi_term_t term_sel(input logic [1:0] lane, input logic [1:0] term);
    gqi_term_t t;
    case ({lane, term})
      {Q_W, 2'd0}: t = '{q_idx: Q_X, r_idx: R_X, neg: 1'b1};
      {Q_W, 2'd1}: t = '{q_idx: Q_Y, r_idx: R_Y, neg: 1'b1};
      {Q_W, 2'd2}: t = '{q_idx: Q_Z, r_idx: R_Z, neg: 1'b1};
      {Q_X, 2'd0}: t = '{q_idx: Q_W, r_idx: R_X, neg: 1'b0};
      {Q_X, 2'd1}: t = '{q_idx: Q_Y, r_idx: R_Z, neg: 1'b0};
      {Q_X, 2'd2}: t = '{q_idx: Q_Z, r_idx: R_Y, neg: 1'b1};
      {Q_Y, 2'd0}: t = '{q_idx: Q_W, r_idx: R_Y, neg: 1'b0};
      {Q_Y, 2'd1}: t = '{q_idx: Q_Z, r_idx: R_X, neg: 1'b0};
      {Q_Y, 2'd2}: t = '{q_idx: Q_X, r_idx: R_Z, neg: 1'b1};
      {Q_Z, 2'd0}: t = '{q_idx: Q_W, r_idx: R_Z, neg: 1'b0};
      {Q_Z, 2'd1}: t = '{q_idx: Q_X, r_idx: R_Y, neg: 1'b0};
      {Q_Z, 2'd2}: t = '{q_idx: Q_Y, r_idx: R_X, neg: 1'b1};
      default:     t = '{q_idx: Q_W, r_idx: R_X, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> src/gqi_lane.sv
// ----------------------------------------------------------------------------
// gqi_lane
// One quaternion part: derivative sum, time scaling, shrink, square and the
// final division by the norm.
// ----------------------------------------------------------------------------
`default_nettype none

module gqi_lane #(
  parameter int LANE      = 0,
  parameter int FRAC_BITS = gqi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire gqi_pkg::gqi_ctrl_t ctrl,
  input  wire gqi_pkg::gqi_quat_t quat,
  input  wire gqi_pkg::gqi_rate_t rate,
  input  wire logic [23:0]        step_time,
  input  wire logic [3:0]         sh,
  input  wire logic [31:0]        root,
  input  wire logic               zero,
  output logic [39:0]             mag,
  output logic [63:0]             square,
  output logic [31:0]             result
);
  import gqi_pkg::*;

  localparam int LOW_W = FRAC_BITS + 1;
  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  gqi_term_t               sel;
  logic signed [55:0]      prod;
  logic signed [57:0]      addend;
  logic signed [57:0]      acc;
  logic signed [40:0]      tdiv;
  logic signed [45:0]      ph;
  logic [43:0]             pl;
  logic signed [63:0]      scaled;
  logic signed [40:0]      p;
  logic signed [40:0]      psh;
  logic signed [32:0]      ps;
  logic [31:0]             mag32;
  logic [63:0]             num;
  logic [32:0]             rem;
  logic [32:0]             trial;
  logic                    ge;
  logic [LOW_W-1:0]        low;
  logic [LOW_W-1:0]        quot;
  logic signed [33:0]      val;

  // Product of the selected quaternion part and rate axis.
  assign sel    = term_sel(2'(LANE), ctrl.term);
  assign prod   = $signed(quat[sel.q_idx]) * $signed(rate[sel.r_idx]);
  assign addend = sel.neg ? -58'(prod) : 58'(prod);

  // Halving and the coarse step of the time scaling.
  assign tdiv   = 41'(acc >>> 17);
  assign scaled = (64'(ph) <<< 20) + $signed(64'(pl)) + 64'sd8388608;

  // Shared shift of the merging stage applied to this part.
  assign psh = p >>> sh;
  assign mag = 40'(p[40] ? -p : p);

  // Divider load value and trial subtraction.
  assign num   = (64'(mag32) << FRAC_BITS) + 64'(root >> 1);
  assign trial = {rem[31:0], low[LOW_W-1]};
  assign ge    = trial >= {1'b0, root};

  always_ff @(posedge clk) begin
    if (ctrl.mac) begin
      acc <= ((ctrl.term == 2'd0) ? 58'sd0 : acc) + addend;
    end
    if (ctrl.scale_a) begin
      ph <= $signed(tdiv[40:20]) * $signed({1'b0, step_time});
      pl <= tdiv[19:0] * step_time;
    end
    if (ctrl.scale_b) begin
      p <= 41'($signed(quat[LANE])) + 41'(scaled >>> 24);
    end
    if (ctrl.shrink) begin
      ps    <= 33'(psh);
      mag32 <= 32'(psh[40] ? -psh : psh);
    end
    if (ctrl.square) begin
      square <= 64'(mag32) * 64'(mag32);
    end
    if (ctrl.div_load) begin
      rem  <= 33'(num >> LOW_W);
      low  <= num[LOW_W-1:0];
      quot <= '0;
    end else if (ctrl.div_step) begin
      rem  <= ge ? (trial - {1'b0, root}) : trial;
      low  <= low << 1;
      quot <= {quot[LOW_W-2:0], ge};
    end
  end

  // Sign, zero-norm bypass and clamp to plus or minus one.
  always_comb begin
    if (zero) begin
      val = 34'(ps);
    end else if (ps[32]) begin
      val = -$signed(34'(quot));
    end else begin
      val = $signed(34'(quot));
    end
    if (val > ONE) begin
      val = ONE;
    end else if (val < -ONE) begin
      val = -ONE;
    end
    result = 32'(val);
  end

endmodule

`default_nettype wire

>>> src/gqi_merge.sv
// ----------------------------------------------------------------------------
// gqi_merge
// Combines the four lanes: peak magnitude, shared shift, sum of squares and
// the bitwise integer square root of that sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gqi_merge (
  input  wire logic                  clk,
  input  wire gqi_pkg::gqi_ctrl_t    ctrl,
  input  wire gqi_pkg::gqi_mags_t    mags,
  input  wire gqi_pkg::gqi_squares_t squares,
  output logic [3:0]                 sh,
  output logic [31:0]                root,
  output logic                       zero
);
  import gqi_pkg::*;

  logic [39:0] peak_next;
  logic [39:0] peak;
  logic [3:0]  sh_next;
  logic [63:0] total;
  logic [63:0] rest;
  logic [63:0] acc_root;
  logic [63:0] bitv;
  logic [63:0] probe;

  // Largest magnitude over the lanes.
  always_comb begin
    peak_next = mags[0];
    for (int i = 1; i < 4; i++) begin
      if (mags[i] > peak_next) begin
        peak_next = mags[i];
      end
    end
  end

  // Least right shift that brings the peak below two to the 31.
  always_comb begin
    sh_next = '0;
    for (int k = 0; k < 10; k++) begin
      if ((peak >> k) >= 40'h0080000000) begin
        sh_next = sh_next + 4'd1;
      end
    end
  end

  assign total = squares[0] + squares[1] + squares[2] + squares[3];
  assign probe = acc_root + bitv;
  assign root  = acc_root[31:0];

  always_ff @(posedge clk) begin
    if (ctrl.peak) begin
      peak <= peak_next;
    end
    if (ctrl.shift) begin
      sh <= sh_next;
    end
    if (ctrl.sum) begin
      rest     <= total;
      acc_root <= '0;
      bitv     <= 64'h4000_0000_0000_0000;
      zero     <= (total == 64'd0);
    end else if (ctrl.root) begin
      if (rest >= probe) begin
        rest     <= rest - probe;
        acc_root <= (acc_root >> 1) + bitv;
      end else begin
        acc_root <= acc_root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

`default_nettype wire

>>> src/gyro_quaternion_integrator_top.sv
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator_top
// First-order quaternion integration of gyro rates with normalisation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one gyro sample per
//   beat. Output channel (out_valid, out_stall, out_data) carries the updated,
//   normalised orientation, one beat per sample. cfg_we with cfg_data writes
//   the sample interval; write it only while the block is idle.
// Sequence:
//   One sample at a time. From acceptance to the result the block runs the
//   multiply-accumulate steps of each lane, the scaling steps, the merging
//   steps, the bitwise square root, the divider load, the per-lane divider
//   and a finishing step. The next sample is taken in the cycle after the
//   result is registered.
// Reset:
//   The orientation returns to the identity, the interval to its default and
//   both channels go quiet.
// Stall:
//   A finished result waits in the output register while the next sample is
//   worked on; a further result waits for that register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_quaternion_integrator_top #(
  parameter int FRAC_BITS = gqi_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gqi_pkg::gqi_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output gqi_pkg::gqi_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [23:0]      cfg_data
);
  import gqi_pkg::*;

  localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
  localparam logic [5:0]  DIV_LAST = 6'(FRAC_BITS);
  localparam logic [5:0]  ROOT_LAST = 6'(ROOT_STEPS - 1);

  gqi_state_t   state;
  gqi_state_t   state_next;
  logic [5:0]   cnt;
  logic [5:0]   cnt_next;
  gqi_ctrl_t    ctrl;
  logic [23:0]  step_time;
  gqi_quat_t    orient;
  gqi_rate_t    rate;
  gqi_mags_t    mags;
  gqi_squares_t squares;
  gqi_quat_t    results;
  logic [3:0]   sh;
  logic [31:0]  root;
  logic         zero;
  logic         commit;

  assign in_stall = (state != ST_IDLE);
  assign commit   = (state == ST_FINISH) && (!out_valid || !out_stall);

  // Next state and step counter.
  always_comb begin
    state_next = state;
    cnt_next   = cnt + 6'd1;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (cnt == 6'd2) begin
          state_next = ST_SCALE_A;
        end
      end
      ST_SCALE_A:  state_next = ST_SCALE_B;
      ST_SCALE_B:  state_next = ST_PEAK;
      ST_PEAK:     state_next = ST_SHIFT;
      ST_SHIFT:    state_next = ST_SHRINK;
      ST_SHRINK:   state_next = ST_SQUARE;
      ST_SQUARE:   state_next = ST_SUM;
      ST_SUM: begin
        state_next = ST_ROOT;
        cnt_next   = '0;
      end
      ST_ROOT: begin
        if (cnt == ROOT_LAST) begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIVIDE;
        cnt_next   = '0;
      end
      ST_DIVIDE: begin
        if (cnt == DIV_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Step strobes for the lanes and the merging stage.
  always_comb begin
    ctrl      = '0;
    ctrl.term = cnt[1:0];
    case (state)
      ST_MAC:      ctrl.mac      = 1'b1;
      ST_SCALE_A:  ctrl.scale_a  = 1'b1;
      ST_SCALE_B:  ctrl.scale_b  = 1'b1;
      ST_PEAK:     ctrl.peak     = 1'b1;
      ST_SHIFT:    ctrl.shift    = 1'b1;
      ST_SHRINK:   ctrl.shrink   = 1'b1;
      ST_SQUARE:   ctrl.square   = 1'b1;
      ST_SUM:      ctrl.sum      = 1'b1;
      ST_ROOT:     ctrl.root     = 1'b1;
      ST_DIV_LOAD: ctrl.div_load = 1'b1;
      ST_DIVIDE:   ctrl.div_step = 1'b1;
      default:     ctrl.term     = cnt[1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      step_time <= STEP_TIME_RESET;
      orient    <= {32'd0, 32'd0, 32'd0, ONE_Q};
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_we) begin
        step_time <= cfg_data;
      end
      if (commit) begin
        orient    <= results;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sample capture and output register.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rate <= {in_data.rate_z, in_data.rate_y, in_data.rate_x};
    end
    if (commit) begin
      out_data <= {results[0], results[1], results[2], results[3]};
    end
  end

  // Four lanes, one per quaternion part.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    gqi_lane #(
      .LANE      (i),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .quat      ({orient[3], orient[2], orient[1], orient[0]}),
      .rate      ({rate[2], rate[1], rate[0]}),
      .step_time (step_time),
      .sh        (sh),
      .root      (root),
      .zero      (zero),
      .mag       (mags[i]),
      .square    (squares[i]),
      .result    (results[i])
    );
  end

  gqi_merge u_merge (
    .clk     (clk),
    .ctrl    (ctrl),
    .mags    (mags),
    .squares (squares),
    .sh      (sh),
    .root    (root),
    .zero    (zero)
  );

  // A sample taken is worked on alone until its result is committed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sample accepted while another is in flight");

  // The w and z parts of a fresh result equal those of the orientation kept for the next sample.
  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.quat_w == orient[0]) && (out_data.quat_z == orient[3]))
    else $error("emitted orientation differs from stored orientation");

  // The x part of a result stays within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_data.quat_x) <= $signed({1'b0, ONE_Q}))
              && ($signed(out_data.quat_x) >= -$signed({1'b0, ONE_Q})))
    else $error("result outside unit range");

  // A commit into an empty output register shows up in the next cycle.
  a_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_valid) |=> out_valid && (state == ST_IDLE))
    else $error("finished result not delivered");

endmodule

`default_nettype wire

>>> test/gyro_quaternion_integrator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator_top_tb
// Drives gyro samples through the integrator under random idling on both
// channels. A local fixed-point model of the quaternion update and
// normalisation predicts each orientation beat, which is compared field by
// field with what the block emits. The sample interval is changed between
// phases, including both of its extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_quaternion_integrator_top_tb;
  import gqi_pkg::*;

  localparam int  FRAC = 30;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int  DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  gqi_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gqi_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;

  gyro_quaternion_integrator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state: orientation and sample interval.
  longint   orient [4];
  longint   interval;
  gqi_in_t  sample_queue [$];
  gqi_out_t orient_queue [$];
  int       failures = 0;
  bit       quiet_tail = 1'b0;
  longint   cycle_count = 0;

  // Acceptance flag captured at the rising edge, and the sender pause.
  logic accepted_in = 1'b0;
  bit   hold_off = 1'b0;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint scaled_delta(longint s);
    longint t;
    t = floor_shr(s, 17);
    return floor_shr(t * interval + (64'sd1 <<< 23), 24);
  endfunction

  function automatic longint unsigned root64(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Work out the next orientation for one gyro sample and update the model.
  function automatic gqi_out_t integrate_sample(gqi_in_t s);
    longint rx, ry, rz, w, x, y, z;
    longint p [4];
    longint unsigned mag [4];
    longint unsigned peak, total, n, qv;
    int sh;
    gqi_out_t o;
    rx = longint'(s.rate_x);
    ry = longint'(s.rate_y);
    rz = longint'(s.rate_z);
    w = orient[0]; x = orient[1]; y = orient[2]; z = orient[3];
    p[0] = w + scaled_delta(-(x * rx + y * ry + z * rz));
    p[1] = x + scaled_delta(w * rx + y * rz - z * ry);
    p[2] = y + scaled_delta(w * ry + z * rx - x * rz);
    p[3] = z + scaled_delta(w * rz + x * ry - y * rx);
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = p[i] < 0 ? longint'(-p[i]) : longint'(p[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    sh = 0;
    while ((peak >> sh) >= (64'd1 << 31)) sh++;
    total = 0;
    for (int i = 0; i < 4; i++) begin
      p[i] = floor_shr(p[i], sh);
      mag[i] = p[i] < 0 ? longint'(-p[i]) : longint'(p[i]);
      total += mag[i] * mag[i];
    end
    // A zero norm leaves the shifted parts as they are.
    if (total != 0) begin
      n = root64(total);
      for (int i = 0; i < 4; i++) begin
        qv = ((mag[i] << FRAC) + (n >> 1)) / n;
        p[i] = p[i] < 0 ? -longint'(qv) : longint'(qv);
      end
    end
    // Clamp to plus or minus one.
    for (int i = 0; i < 4; i++) begin
      if (p[i] > ONE) p[i] = ONE;
      if (p[i] < -ONE) p[i] = -ONE;
      orient[i] = p[i];
    end
    o.quat_w = p[0][31:0];
    o.quat_x = p[1][31:0];
    o.quat_y = p[2][31:0];
    o.quat_z = p[3][31:0];
    return o;
  endfunction

  // Sample driver: bursts of idling unless the tail of the run is quiet.
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_in) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0 && !hold_off) begin
          if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_gap <= $urandom_range(1, 10) - 1;
            in_valid <= 1'b0;
          end else begin
            in_data <= sample_queue.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Input monitor: record acceptance and predict the result.
  always @(posedge clk) begin
    accepted_in <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      orient_queue.push_back(integrate_sample(in_data));
  end

  // Result stall generator.
  int out_gap = 0;
  always @(negedge clk) begin
    if (quiet_tail || rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    gqi_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (orient_queue.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        failures++;
      end else begin
        want = orient_queue.pop_front();
        if (out_data.quat_w !== want.quat_w) begin
          $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w, out_data.quat_w);
          failures++;
        end
        if (out_data.quat_x !== want.quat_x) begin
          $display("%0t: quat_x expected %0d actual %0d", $time, want.quat_x, out_data.quat_x);
          failures++;
        end
        if (out_data.quat_y !== want.quat_y) begin
          $display("%0t: quat_y expected %0d actual %0d", $time, want.quat_y, out_data.quat_y);
          failures++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z, out_data.quat_z);
          failures++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gyro_quaternion_integrator_top_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [23:0] random_rate(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic add_sample(logic [23:0] a, logic [23:0] b, logic [23:0] c);
    gqi_in_t s;
    s.rate_x = a;
    s.rate_y = b;
    s.rate_z = c;
    sample_queue.push_back(s);
  endtask

  // Wait until everything queued has been taken and answered, then settle.
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || orient_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    interval = v;
  endtask

  task automatic random_phase(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
      add_sample(random_rate(mode), random_rate(mode), random_rate(mode));
    end
  endtask

  initial begin
    interval = STEP_TIME_RESET;
    orient[0] = ONE;
    orient[1] = 0; orient[2] = 0; orient[3] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero rate, field extremes, each axis alone, all-ones and alternating-bit patterns.
    add_sample(24'd0, 24'd0, 24'd0);
    add_sample(24'h7FFFFF, 24'd0, 24'd0);
    add_sample(24'd0, 24'h7FFFFF, 24'd0);
    add_sample(24'd0, 24'd0, 24'h7FFFFF);
    add_sample(24'h800000, 24'd0, 24'd0);
    add_sample(24'd0, 24'h800000, 24'd0);
    add_sample(24'd0, 24'd0, 24'h800000);
    add_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_sample(24'h800000, 24'h800000, 24'h800000);
    add_sample(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
    add_sample(24'h555555, 24'hAAAAAA, 24'h555555);
    add_sample(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    drain();

    // Largest interval with full-scale rates gives big excursions.
    write_interval(24'hFFFFFF);
    add_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    add_sample(24'h800000, 24'h7FFFFF, 24'h123456);
    random_phase(300);
    drain();

    // Zero interval: orientation only renormalises.
    write_interval(24'd0);
    add_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    random_phase(150);
    drain();

    // Pause the sender until all results are in, then carry on.
    write_interval(24'd1);
    random_phase(100);
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    while (in_valid || orient_queue.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    drain();

    write_interval(24'd167772);
    random_phase(350);
    drain();

    write_interval(24'($urandom));
    random_phase(300);
    quiet_tail = 1'b1;
    random_phase(80);
    drain();

    if (failures == 0) begin
      $display("gyro_quaternion_integrator_top_tb OK");
    end else begin
      $display("gyro_quaternion_integrator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
